// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int MODE_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_BACK  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_BACK   = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_READ = 2'd1,
		ST_LOAD = 2'd2
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take_in;
		logic load_out;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} ctrl_stat_t;

endpackage

// File: rtl/core/deq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: one deque operation per item.
// ----------------------------------------------------------------------------
interface deq_req_if;
	logic                            valid;
	logic                            ready;
	logic [deq_pkg::MODE_W-1:0]      mode;
	logic signed [deq_pkg::VALUE_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface

// File: rtl/core/deq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_rsp_if
// Response channel: deque state after each operation.
// ----------------------------------------------------------------------------
interface deq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [deq_pkg::VALUE_W-1:0] front_value;
	logic signed [deq_pkg::VALUE_W-1:0] back_value;
	logic [deq_pkg::COUNT_W-1:0]        count;
	logic [deq_pkg::STATUS_W-1:0]       status;

	modport source (output valid, output front_value, output back_value, output count,
		output status, input ready);
	modport sink   (input valid, input front_value, input back_value, input count,
		input status, output ready);
endinterface

// File: rtl/core/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept an item, read back the ends, load the output register.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  deq_pkg::ctrl_stat_t stat,
	output deq_pkg::ctrl_cmd_t  cmd
);

	deq_pkg::state_t state_q;
	deq_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				if (req_valid) state_nxt = deq_pkg::ST_READ;
			end
			deq_pkg::ST_READ: begin
				state_nxt = deq_pkg::ST_LOAD;
			end
			deq_pkg::ST_LOAD: begin
				if (stat.out_free) state_nxt = deq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = deq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		cmd.take_in  = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.take_in = req_valid;
			end
			deq_pkg::ST_READ: begin
			end
			deq_pkg::ST_LOAD: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("output loaded while occupied");
	a_take_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_in |=> state_q == deq_pkg::ST_READ)
		else $error("accepted item not followed by read");
	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == deq_pkg::ST_READ |=> state_q == deq_pkg::ST_LOAD && !req_ready)
		else $error("read not followed by load");
`endif

endmodule

// File: rtl/core/deq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_dpath
// Ring pointers, element count, element memory and output register.
// ----------------------------------------------------------------------------
module deq_dpath #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  deq_pkg::ctrl_cmd_t                  cmd,
	output deq_pkg::ctrl_stat_t                 stat,
	input  logic [deq_pkg::MODE_W-1:0]          in_mode,
	input  logic signed [deq_pkg::VALUE_W-1:0]  in_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [deq_pkg::VALUE_W-1:0]  out_front_value,
	output logic signed [deq_pkg::VALUE_W-1:0]  out_back_value,
	output logic [deq_pkg::COUNT_W-1:0]         out_count,
	output logic [deq_pkg::STATUS_W-1:0]        out_status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	deq_pkg::status_t status_q;
	logic             out_valid_q;

	logic [PTR_W-1:0] head_prev, head_next, tail_prev, tail_next;
	logic [PTR_W-1:0] head_nxt, tail_nxt, waddr;
	logic [CNT_W-1:0] count_nxt;
	deq_pkg::status_t status_nxt;
	logic             we;
	deq_pkg::mode_t   mode;
	logic             is_full, is_empty;

	logic [DATA_WIDTH-1:0]       wdata, front_raw, back_raw;
	logic [deq_pkg::VALUE_W-1:0] front_ext, back_ext;
	logic [deq_pkg::COUNT_W-1:0] count_ext;

	assign head_prev = (head_q == '0) ? PTR_LAST : head_q - PTR_W'(1);
	assign head_next = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
	assign tail_prev = (tail_q == '0) ? PTR_LAST : tail_q - PTR_W'(1);
	assign tail_next = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);

	assign mode     = deq_pkg::mode_t'(in_mode);
	assign is_full  = (count_q == CNT_FULL);
	assign is_empty = (count_q == '0);

	always_comb begin
		head_nxt   = head_q;
		tail_nxt   = tail_q;
		count_nxt  = count_q;
		status_nxt = deq_pkg::STATUS_DONE;
		we         = 1'b0;
		waddr      = tail_q;
		unique case (mode)
			deq_pkg::MODE_PUSH_FRONT: begin
				waddr = head_prev;
				if (is_full) begin
					status_nxt = deq_pkg::STATUS_FULL;
				end else begin
					head_nxt  = head_prev;
					count_nxt = count_q + CNT_W'(1);
					we        = 1'b1;
				end
			end
			deq_pkg::MODE_PUSH_BACK: begin
				if (is_full) begin
					status_nxt = deq_pkg::STATUS_FULL;
				end else begin
					tail_nxt  = tail_next;
					count_nxt = count_q + CNT_W'(1);
					we        = 1'b1;
				end
			end
			deq_pkg::MODE_POP_FRONT: begin
				if (is_empty) begin
					status_nxt = deq_pkg::STATUS_EMPTY;
				end else begin
					head_nxt  = head_next;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			deq_pkg::MODE_POP_BACK: begin
				if (is_empty) begin
					status_nxt = deq_pkg::STATUS_EMPTY;
				end else begin
					tail_nxt  = tail_prev;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			status_q <= deq_pkg::STATUS_DONE;
		end else if (cmd.take_in) begin
			head_q   <= head_nxt;
			tail_q   <= tail_nxt;
			count_q  <= count_nxt;
			status_q <= status_nxt;
		end
	end

	// a narrower memory stores the low DATA_WIDTH bits, read back zero-extended
	generate
		if (DATA_WIDTH >= deq_pkg::VALUE_W) begin : g_wide
			assign wdata     = DATA_WIDTH'(unsigned'(in_value));
			assign front_ext = front_raw[deq_pkg::VALUE_W-1:0];
			assign back_ext  = back_raw[deq_pkg::VALUE_W-1:0];
		end else begin : g_narrow
			assign wdata     = in_value[DATA_WIDTH-1:0];
			assign front_ext = {{(deq_pkg::VALUE_W-DATA_WIDTH){1'b0}}, front_raw};
			assign back_ext  = {{(deq_pkg::VALUE_W-DATA_WIDTH){1'b0}}, back_raw};
		end
		if (CNT_W >= deq_pkg::COUNT_W) begin : g_cnt_trunc
			assign count_ext = count_q[deq_pkg::COUNT_W-1:0];
		end else begin : g_cnt_ext
			assign count_ext = {{(deq_pkg::COUNT_W-CNT_W){1'b0}}, count_q};
		end
	endgenerate

	// ends are read continuously; data is settled by the load state
	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.take_in && we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (head_q),
		.raddr_b (tail_prev),
		.rdata_a (front_raw),
		.rdata_b (back_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_front_value <= is_empty ? '0 : signed'(front_ext);
			out_back_value  <= is_empty ? '0 : signed'(back_ext);
			out_count       <= count_ext;
			out_status      <= status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || out_ready;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("element count beyond depth");
	a_full_insert_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_in && is_full &&
		(mode == deq_pkg::MODE_PUSH_FRONT || mode == deq_pkg::MODE_PUSH_BACK)
		|=> $stable(count_q) && $stable(head_q) && $stable(tail_q)
			&& status_q == deq_pkg::STATUS_FULL)
		else $error("rejected insert changed the ring");
	a_idle_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.take_in |=> $stable(count_q) && $stable(head_q) && $stable(tail_q))
		else $error("ring state changed without an item");
`endif

endmodule

// File: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque on a ring buffer, one operation per request item.
// ----------------------------------------------------------------------------
// Each request item inserts at the front or back, or removes from the front
// or back; each yields one response item with the front value, back value,
// element count and status after the operation (front and back read as zero
// when the deque is empty). An item goes through three steps: accept and
// update of the head/tail pointers and count with the memory write, a read
// of both ends from the element memory, whose read port is registered, and
// the load of the response register. A new request is taken once the
// previous response is loaded, so the block takes no new item before it
// is through with the last one. After reset the deque is empty.
module double_ended_queue #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input logic     clk,
	input logic     arst_n,
	deq_req_if.sink req,
	deq_rsp_if.source rsp
);

	deq_pkg::ctrl_cmd_t  cmd;
	deq_pkg::ctrl_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_mode         (req.mode),
		.in_value        (req.value),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_front_value (rsp.front_value),
		.out_back_value  (rsp.back_value),
		.out_count       (rsp.count),
		.out_status      (rsp.status)
	);

endmodule

// File: tb/deq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker
// Watches the request and response channels of the deque, keeps its own
// ring-buffer model of the contents and compares every response item with
// the state that the accepted request should leave behind.
// ----------------------------------------------------------------------------
module deq_checker
	import deq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	deq_req_if    req,
	deq_rsp_if    rsp,
	output int    errors,
	output int    outstanding
);

	localparam int RING = 16;

	typedef struct packed {
		logic [VALUE_W-1:0]  front;
		logic [VALUE_W-1:0]  back;
		logic [COUNT_W-1:0]  cnt;
		logic [STATUS_W-1:0] st;
	} deq_view_t;

	logic [VALUE_W-1:0] ring_mem [RING];
	logic [3:0]         head_ptr;
	logic [3:0]         tail_ptr;   // next slot a back insert fills
	logic [COUNT_W-1:0] fill;

	deq_view_t expected_views[$];
	int        fail_cnt;

	initial begin
		head_ptr    = '0;
		tail_ptr    = '0;
		fill        = '0;
		fail_cnt    = 0;
		outstanding = 0;
	end

	assign errors = fail_cnt;

	// Apply one operation to the model and return the state it exposes.
	function automatic deq_view_t deque_apply(logic [MODE_W-1:0] op, logic [VALUE_W-1:0] v);
		deq_view_t r;
		r.st = STATUS_DONE;
		case (mode_t'(op))
			MODE_PUSH_FRONT: begin
				if (fill == RING) begin
					r.st = STATUS_FULL;
				end else begin
					head_ptr           = head_ptr - 4'd1;
					ring_mem[head_ptr] = v;
					fill               = fill + 1'b1;
				end
			end
			MODE_PUSH_BACK: begin
				if (fill == RING) begin
					r.st = STATUS_FULL;
				end else begin
					ring_mem[tail_ptr] = v;
					tail_ptr           = tail_ptr + 4'd1;
					fill               = fill + 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (fill == 0) begin
					r.st = STATUS_EMPTY;
				end else begin
					head_ptr = head_ptr + 4'd1;
					fill     = fill - 1'b1;
				end
			end
			default: begin
				if (fill == 0) begin
					r.st = STATUS_EMPTY;
				end else begin
					tail_ptr = tail_ptr - 4'd1;
					fill     = fill - 1'b1;
				end
			end
		endcase
		r.cnt = fill;
		if (fill == 0) begin
			r.front = '0;
			r.back  = '0;
		end else begin
			r.front = ring_mem[head_ptr];
			r.back  = ring_mem[4'(tail_ptr - 4'd1)];
		end
		return r;
	endfunction

	task automatic log_failure(string what, deq_view_t e, deq_view_t a);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("[%0t] %s: exp front=%h back=%h count=%0d status=%0d | act front=%h back=%h count=%0d status=%0d",
				$time, what, e.front, e.back, e.cnt, e.st, a.front, a.back, a.cnt, a.st);
	endtask

	always @(posedge clk) begin
		deq_view_t got;
		deq_view_t want;
		if (arst_n) begin
			// log the request first so a same-edge response still finds it
			if (req.valid && req.ready)
				expected_views.push_back(deque_apply(req.mode, req.value));
			if (rsp.valid && rsp.ready) begin
				got.front = rsp.front_value;
				got.back  = rsp.back_value;
				got.cnt   = rsp.count;
				got.st    = rsp.status;
				if (expected_views.size() == 0) begin
					want = '0;
					log_failure("unexpected response", want, got);
				end else begin
					want = expected_views.pop_front();
					if (got.front !== want.front || got.back !== want.back ||
						got.cnt !== want.cnt || got.st !== want.st)
						log_failure("response mismatch", want, got);
				end
			end
			outstanding = expected_views.size();
		end
	end

endmodule

// File: tb/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Drives deque operations with random source and sink stalls: a few
// directed corner items, then fill-to-full, drain-to-empty and mixed runs
// with random data. The checker scores every response item.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
	import deq_pkg::*;

	localparam int  HALF_HI      = 6;
	localparam int  HALF_LO      = 6;
	localparam int  RESET_CYCLES = 9;
	localparam int  ITEM_TARGET  = 1100;
	localparam int  CALM_FROM    = 950;
	localparam int  DRAIN_CYCLES = 20;
	localparam int  CYCLE_LIMIT  = 400000;
	localparam int  RING         = 16;

	logic clk;
	logic arst_n;
	int   err_cnt;
	int   pend_cnt;
	int   cycles;
	int   sent;
	int   depth_est;
	logic src_idle_en;
	logic snk_idle_en;
	logic calm;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (err_cnt),
		.outstanding (pend_cnt)
	);

	always begin
		clk = 1'b1;
		#HALF_HI;
		clk = 1'b0;
		#HALF_LO;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL double_ended_queue");
			$finish;
		end
	end

	// response side: ready drops in bursts while stalling is enabled
	initial begin
		int stall;
		stall        = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				stall--;
			end else if (!calm && snk_idle_en && $urandom_range(0, 5) == 0) begin
				stall        = $urandom_range(1, 15) - 1;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			4:       return 32'h1 << $urandom_range(0, 31);
			5:       return ~(32'h1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	function automatic mode_t any_push();
		return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
	endfunction

	function automatic mode_t any_pop();
		return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
	endfunction

	// Present one item and hold it until accepted; valid stays high into the
	// next item unless a source gap is taken.
	task automatic send_op(input mode_t m, input logic [VALUE_W-1:0] v);
		int gap;
		if (!calm && src_idle_en && $urandom_range(0, 4) == 0) begin
			req_ch.valid = 1'b0;
			gap          = $urandom_range(1, 15);
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.mode  = m;
		req_ch.value = v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sent++;
		if ((m == MODE_PUSH_FRONT || m == MODE_PUSH_BACK) && depth_est < RING)
			depth_est++;
		else if ((m == MODE_POP_FRONT || m == MODE_POP_BACK) && depth_est > 0)
			depth_est--;
		@(negedge clk);
	endtask

	initial begin
		int n;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode  = MODE_PUSH_FRONT;
		req_ch.value = '0;
		sent         = 0;
		depth_est    = 0;
		src_idle_en  = 1'b1;
		snk_idle_en  = 1'b1;
		calm         = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed corners: removals from empty, extreme values, head wrap
		send_op(MODE_POP_FRONT, 32'h1234_5678);
		send_op(MODE_POP_BACK, '1);
		send_op(MODE_PUSH_FRONT, 32'h8000_0000);
		send_op(MODE_PUSH_BACK, 32'h7FFF_FFFF);
		send_op(MODE_PUSH_FRONT, '1);
		send_op(MODE_PUSH_BACK, '0);
		send_op(MODE_POP_FRONT, '0);
		send_op(MODE_POP_BACK, '0);
		send_op(MODE_POP_FRONT, '0);
		send_op(MODE_POP_BACK, '0);
		send_op(MODE_POP_BACK, '0);
		send_op(MODE_PUSH_BACK, 32'hA5A5_5A5A);
		send_op(MODE_POP_FRONT, '1);
		send_op(MODE_PUSH_FRONT, 32'h5A5A_A5A5);
		send_op(MODE_POP_BACK, '1);
		send_op(MODE_POP_FRONT, '0);

		while (sent < ITEM_TARGET) begin
			calm        = (sent >= CALM_FROM);
			src_idle_en = ($urandom_range(0, 2) != 0);
			snk_idle_en = ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 3))
				0: begin
					// fill to the brim, then knock on a full deque
					while (depth_est < RING) send_op(any_push(), pick_value());
					n = $urandom_range(1, 3);
					repeat (n) send_op(any_push(), pick_value());
				end
				1: begin
					while (depth_est > 0) send_op(any_pop(), pick_value());
					n = $urandom_range(1, 3);
					repeat (n) send_op(any_pop(), pick_value());
				end
				default: begin
					n = $urandom_range(5, 30);
					repeat (n) send_op(mode_t'($urandom_range(0, 3)), pick_value());
				end
			endcase
		end
		req_ch.valid = 1'b0;

		wait (pend_cnt == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && pend_cnt == 0)
			$display("PASS double_ended_queue");
		else
			$display("FAIL double_ended_queue");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/deq_pkg.sv
rtl/core/deq_req_if.sv
rtl/core/deq_rsp_if.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_dpath.sv
rtl/core/double_ended_queue.sv
tb/deq_checker.sv
tb/tb_double_ended_queue.sv
